@@ rtl/core/bdl_pkg.sv @@
// bdl_pkg: types and codes shared by the bounded deque list.
// Request and result payload structs, action codes, status codes, command struct.
// No dependencies.
package bdl_pkg;

    localparam int ACTION_W   = 3;
    localparam int IN_VALUE_W = 32;
    localparam int POSITION_W = 8;
    localparam int OUT_VALUE_W = 32;
    localparam int OUT_SIZE_W = 9;
    localparam int STATUS_W   = 2;
    localparam int WIDE_W     = 64;

    localparam logic [ACTION_W-1:0] ACT_INS_HEAD = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_TAIL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REM_HEAD = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REM_TAIL = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RD_HEAD  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RD_TAIL  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RD_POS   = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [IN_VALUE_W-1:0] element_value;
        logic [POSITION_W-1:0] position;
    } t_bdl_in;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] read_value;
        logic [OUT_SIZE_W-1:0]  list_size;
        logic [STATUS_W-1:0]    status;
    } t_bdl_out;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;  // request accepted: update ring, issue memory access
        logic load;  // move finished result into the output register
    } t_bdl_cmd;

endpackage

@@ rtl/core/bdl_ram.sv @@
// bdl_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bdl_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/bdl_ctrl.sv @@
// bdl_ctrl: request sequencer for the bounded deque list.
// Depends on bdl_pkg (command struct).
module bdl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bdl_pkg::t_bdl_cmd o_cmd
);
    import bdl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd.exec = 1'b0;
        o_cmd.load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                // hold until the output register can take the result
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/bdl_dpath.sv @@
// bdl_dpath: ring pointers, element memory and result register of the deque list.
// Depends on bdl_pkg and bdl_ram.
module bdl_dpath #(
    parameter int DEPTH      = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdl_pkg::t_bdl_cmd i_cmd,
    input  bdl_pkg::t_bdl_in  i_in,
    output bdl_pkg::t_bdl_out o_out
);
    import bdl_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POSITION_W) ? CW : POSITION_W;

    logic [PW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_rd_sel, n_rd_sel;
    t_bdl_out            r_out;

    logic                  full, empty;
    logic [PW-1:0]         head_dec;
    logic [XW-1:0]         offset;
    logic [PW-1:0]         ring_addr;
    logic [PW-1:0]         mem_addr;
    logic                  mem_we, mem_re;
    logic [WIDE_W-1:0]     wide_in, wide_rd;
    logic [ELEM_WIDTH-1:0] mem_wdata, mem_rdata;

    // base plus offset modulo depth; the sum stays below twice the depth
    function automatic logic [PW-1:0] ring_add(logic [PW-1:0] base, logic [XW-1:0] off);
        logic [XW:0] sum;
        sum = (XW+1)'(base) + (XW+1)'(off);
        if (sum >= (XW+1)'(DEPTH)) begin
            sum = sum - (XW+1)'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign head_dec  = (r_head == '0) ? PW'(DEPTH - 1) : r_head - 1'b1;
    assign ring_addr = ring_add(r_head, offset);

    assign wide_in   = {{(WIDE_W - IN_VALUE_W){1'b0}}, i_in.element_value};
    assign mem_wdata = wide_in[ELEM_WIDTH-1:0];

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        n_rd_sel = 1'b0;
        offset   = '0;
        mem_addr = ring_addr;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        case (i_in.action)
            ACT_INS_HEAD: begin
                mem_addr = head_dec;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we  = 1'b1;
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_INS_TAIL: begin
                offset = XW'(r_count);
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_REM_HEAD: begin
                offset = XW'(1);
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head  = ring_addr;
                    n_count = r_count - 1'b1;
                end
            end
            ACT_REM_TAIL: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            ACT_RD_HEAD: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    mem_re   = 1'b1;
                    n_rd_sel = 1'b1;
                end
            end
            ACT_RD_TAIL: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    offset   = XW'(r_count - 1'b1);
                    mem_re   = 1'b1;
                    n_rd_sel = 1'b1;
                end
            end
            ACT_RD_POS: begin
                offset = XW'(i_in.position);
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (XW'(i_in.position) >= XW'(r_count)) begin
                    n_status = ST_RANGE;
                end else begin
                    mem_re   = 1'b1;
                    n_rd_sel = 1'b1;
                end
            end
            default: begin
                // unused action: report size only
            end
        endcase
    end

    bdl_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH),
        .ADDR_W(PW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.exec && mem_we),
        .i_waddr(mem_addr),
        .i_wdata(mem_wdata),
        .i_re   (i_cmd.exec && mem_re),
        .i_raddr(mem_addr),
        .o_rdata(mem_rdata)
    );

    assign wide_rd = WIDE_W'(mem_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rd_sel <= n_rd_sel;
        end
        if (i_cmd.load) begin
            r_out.read_value <= r_rd_sel ? wide_rd[OUT_VALUE_W-1:0] : '0;
            r_out.list_size  <= OUT_SIZE_W'(r_count);
            r_out.status     <= r_status;
        end
    end

    assign o_out = r_out;

endmodule

@@ rtl/core/bounded_deque_list.sv @@
// bounded_deque_list: fixed-capacity double-ended queue held as a ring in one RAM.
// A request is accepted in the idle state; its element RAM read is registered, then the
// result is loaded into the output register once that register is free. No new request
// is taken until the result is loaded; a result waiting on a stall holds the next request.
// Reset (i_rst_n, synchronous, low): clears head, count, sequencer and output valid;
// element RAM is not cleared and needs no clearing pass.
module bounded_deque_list #(
    parameter int DEPTH      = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bdl_pkg::t_bdl_in  i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output bdl_pkg::t_bdl_out o_out_data,
    input  logic              i_out_stall
);
    import bdl_pkg::*;

    // Commands from the sequencer: exec on the accepting edge, load when the
    // output register is free. The request payload is only sampled on exec.
    t_bdl_cmd cmd;

    // Sequencer: idle takes a request, then waits to drop the result into the
    // output register. Input stall is high whenever it is not idle.
    bdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cmd      (cmd)
    );

    // Datapath: head pointer and count of the ring, the element RAM and the
    // result register. Position p lives at (head + p) modulo DEPTH.
    bdl_dpath #(
        .DEPTH     (DEPTH),
        .ELEM_WIDTH(ELEM_WIDTH)
    ) u_dpath (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_in   (i_in_data),
        .o_out  (o_out_data)
    );

endmodule

@@ tb/bounded_deque_list_tb.sv @@
// bounded_deque_list_tb: self-checking testbench for the bounded deque list.
// Drives requests from a directed table and then random fill, mix and drain phases,
// predicts every result in a shadow ring, and depends on bdl_pkg and the RTL.
module bounded_deque_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdl_pkg::*;

    // Action 7 carries no operation; the block must answer it with the size only.
    localparam logic [ACTION_W-1:0] ACT_NOP = 3'd7;
    localparam int RING_DEPTH = 256;
    localparam int PRESSURE_AFTER = 300;   // results seen before the long hold-off
    localparam int PRESSURE_CYCLES = 400;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } t_mix_mode;

    typedef struct {
        t_bdl_in  req;
        bit       typed;
        t_bdl_out want;
    } t_table_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_bdl_in   i_in_data = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_bdl_out  o_out_data;
    logic      i_out_stall = 1'b0;

    // Shadow copy of the list: ring, head slot and element count.
    logic [OUT_VALUE_W-1:0] shadow_ring [RING_DEPTH];
    logic [7:0]             shadow_head = '0;
    logic [OUT_SIZE_W-1:0]  shadow_count = '0;

    t_bdl_out   pending_results [$];
    t_table_row directed_rows [$];
    int         mismatch_count = 0;
    int         results_seen = 0;
    bit         sender_burst = 1'b0;

    bounded_deque_list i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one request to the shadow list and return the result it should give.
    // Only occupied positions are ever read, so unwritten ring slots stay out of reach.
    function automatic t_bdl_out deque_apply(input t_bdl_in req);
        t_bdl_out   res;
        logic [7:0] slot;
        res = '0;
        res.status = ST_OK;
        case (req.action)
            ACT_INS_HEAD: begin
                if (shadow_count == RING_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_head = shadow_head - 8'd1;
                    shadow_ring[shadow_head] = req.element_value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            ACT_INS_TAIL: begin
                if (shadow_count == RING_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot = shadow_head + shadow_count[7:0];
                    shadow_ring[slot] = req.element_value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            ACT_REM_HEAD: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_head = shadow_head + 8'd1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            ACT_REM_TAIL: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_count = shadow_count - 1'b1;
                end
            end
            ACT_RD_HEAD: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = shadow_ring[shadow_head];
                end
            end
            ACT_RD_TAIL: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // a full list has count 256, whose low byte wraps to the right slot
                    slot = shadow_head + shadow_count[7:0] - 8'd1;
                    res.read_value = shadow_ring[slot];
                end
            end
            ACT_RD_POS: begin
                // an empty list reports empty even when the position is also out of range
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if ({1'b0, req.position} >= shadow_count) begin
                    res.status = ST_RANGE;
                end else begin
                    slot = shadow_head + req.position;
                    res.read_value = shadow_ring[slot];
                end
            end
            default: begin
            end
        endcase
        res.list_size = shadow_count;
        return res;
    endfunction

    // Draw one random request; the mix of actions follows the phase mode.
    function automatic t_bdl_in pick_request(input t_mix_mode mode);
        t_bdl_in req;
        int      r;
        int      ins_w;
        int      rem_w;
        req = '0;
        if ($urandom_range(9) == 0) begin
            req.element_value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end else begin
            req.element_value = $urandom;
        end
        req.position = 8'($urandom_range(255));
        case (mode)
            MODE_FILL: begin
                ins_w = 80;
                rem_w = 5;
            end
            MODE_DRAIN: begin
                ins_w = 5;
                rem_w = 80;
            end
            default: begin
                ins_w = 30;
                rem_w = 30;
            end
        endcase
        r = $urandom_range(99);
        if (r < ins_w) begin
            req.action = $urandom_range(1) ? ACT_INS_HEAD : ACT_INS_TAIL;
        end else if (r < ins_w + rem_w) begin
            req.action = $urandom_range(1) ? ACT_REM_HEAD : ACT_REM_TAIL;
        end else if (r < 97) begin
            case ($urandom_range(2))
                0: req.action = ACT_RD_HEAD;
                1: req.action = ACT_RD_TAIL;
                default: req.action = ACT_RD_POS;
            endcase
            // keep most position reads inside the list, the rest anywhere in the byte
            if (shadow_count != 0 && $urandom_range(3) != 0) begin
                req.position = 8'($urandom_range(int'(shadow_count) - 1));
            end
        end else begin
            req.action = ACT_NOP;
        end
        return req;
    endfunction

    // Add a table row; typed rows carry their result, the rest use the shadow list.
    task automatic table_row(input logic [ACTION_W-1:0] act, input logic [31:0] value,
                             input logic [7:0] pos, input bit typed,
                             input logic [31:0] rd, input int size,
                             input logic [STATUS_W-1:0] st);
        t_table_row row;
        row.req.action = act;
        row.req.element_value = value;
        row.req.position = pos;
        row.typed = typed;
        row.want.read_value = rd;
        row.want.list_size = size[OUT_SIZE_W-1:0];
        row.want.status = st;
        directed_rows.push_back(row);
    endtask

    // Offer one request, hold it until accepted, record its expected result,
    // then leave a random gap unless the sender is in a burst.
    task automatic offer_request(input t_bdl_in req, input bit typed, input t_bdl_out want);
        t_bdl_out predicted;
        int       r;
        int       gap;
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall);
        predicted = deque_apply(req);
        pending_results.push_back(typed ? want : predicted);
        r = $urandom_range(99);
        if (sender_burst || r < 60) begin
            gap = 0;
        end else if (r < 92) begin
            gap = $urandom_range(3, 1);
        end else begin
            gap = $urandom_range(30, 6);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver: short random stalls, rare long ones, free windows, and once a
    // long hold-off so the block backs up and stalls its input.
    initial begin : out_stall_gen
        int hold_left;
        int cyc;
        int r;
        bit pressure_done;
        hold_left = 0;
        cyc = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
                pressure_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
            end else if (cyc % 512 < 64) begin
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(99);
                if (r < 70) begin
                    i_out_stall <= 1'b0;
                end else if (r < 95) begin
                    i_out_stall <= 1'b1;
                    hold_left = $urandom_range(2);
                end else begin
                    i_out_stall <= 1'b1;
                    hold_left = $urandom_range(40, 8);
                end
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_bdl_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_value %h list_size %0d status %0d",
                       o_out_data.read_value, o_out_data.list_size, o_out_data.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h",
                           want.read_value, o_out_data.read_value);
                    mismatch_count++;
                end
                if (o_out_data.list_size !== want.list_size) begin
                    $error("list_size: expected %0d, got %0d",
                           want.list_size, o_out_data.list_size);
                    mismatch_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_mix_mode plan_mode [6];
        int        plan_len [6];
        t_bdl_out  no_want;
        no_want = '0;
        plan_mode = '{MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_FILL, MODE_MIX, MODE_DRAIN};
        plan_len = '{400, 120, 360, 180, 80, 160};

        // Directed part: empty-list errors, the unused action, head and tail
        // inserts across the ring wrap, reads of every kind, out-of-range positions.
        table_row(ACT_RD_HEAD,  32'h1234_5678, 8'd0,   1, 32'h0, 0, ST_EMPTY);
        table_row(ACT_RD_TAIL,  32'h0,         8'd0,   1, 32'h0, 0, ST_EMPTY);
        table_row(ACT_RD_POS,   32'h0,         8'd255, 1, 32'h0, 0, ST_EMPTY);
        table_row(ACT_REM_HEAD, 32'h0,         8'd0,   1, 32'h0, 0, ST_EMPTY);
        table_row(ACT_REM_TAIL, 32'h0,         8'd0,   1, 32'h0, 0, ST_EMPTY);
        table_row(ACT_NOP,      32'hFFFF_FFFF, 8'hFF,  1, 32'h0, 0, ST_OK);
        table_row(ACT_INS_HEAD, 32'hFFFF_FFFF, 8'd0,   1, 32'h0, 1, ST_OK);
        table_row(ACT_INS_TAIL, 32'h0000_0000, 8'd0,   1, 32'h0, 2, ST_OK);
        table_row(ACT_INS_HEAD, 32'hA5A5_A5A5, 8'd0,   1, 32'h0, 3, ST_OK);
        table_row(ACT_RD_HEAD,  32'h0,         8'd0,   1, 32'hA5A5_A5A5, 3, ST_OK);
        table_row(ACT_RD_TAIL,  32'h0,         8'd0,   1, 32'h0, 3, ST_OK);
        table_row(ACT_RD_POS,   32'h0,         8'd1,   1, 32'hFFFF_FFFF, 3, ST_OK);
        table_row(ACT_RD_POS,   32'h0,         8'd3,   1, 32'h0, 3, ST_RANGE);
        table_row(ACT_RD_POS,   32'h0,         8'd255, 1, 32'h0, 3, ST_RANGE);
        table_row(ACT_NOP,      32'h5A5A_5A5A, 8'd2,   1, 32'h0, 3, ST_OK);
        table_row(ACT_INS_TAIL, 32'h0000_0001, 8'd0,   0, 32'h0, 0, ST_OK);
        table_row(ACT_INS_HEAD, 32'h8000_0000, 8'd0,   0, 32'h0, 0, ST_OK);
        table_row(ACT_RD_POS,   32'h0,         8'd4,   0, 32'h0, 0, ST_OK);
        table_row(ACT_RD_POS,   32'h0,         8'd0,   0, 32'h0, 0, ST_OK);
        table_row(ACT_REM_TAIL, 32'h0,         8'd0,   0, 32'h0, 0, ST_OK);
        table_row(ACT_REM_HEAD, 32'h0,         8'd0,   0, 32'h0, 0, ST_OK);
        table_row(ACT_RD_TAIL,  32'h0,         8'd0,   0, 32'h0, 0, ST_OK);
        table_row(ACT_REM_HEAD, 32'h0,         8'd0,   0, 32'h0, 0, ST_OK);
        table_row(ACT_REM_HEAD, 32'h0,         8'd0,   0, 32'h0, 0, ST_OK);
        table_row(ACT_REM_TAIL, 32'h0,         8'd0,   0, 32'h0, 0, ST_OK);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            offer_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
        end

        // Random part: fill to the limit, churn, drain past empty, and again.
        // Alternate phases run the sender without gaps.
        for (int p = 0; p < 6; p++) begin
            sender_burst = (p % 2 == 1);
            for (int n = 0; n < plan_len[p]; n++) begin
                offer_request(pick_request(plan_mode[p]), 1'b0, no_want);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/bdl_pkg.sv
rtl/core/bdl_ram.sv
rtl/core/bdl_ctrl.sv
rtl/core/bdl_dpath.sv
rtl/core/bounded_deque_list.sv
tb/bounded_deque_list_tb.sv
